### sv/hks_pkg.sv
package hks_pkg;

    // Hash arithmetic and modulus widths
    localparam int HASH_W = 32;
    localparam int MOD_W  = 5;

    // Configuration register indexes
    localparam logic [1:0] CFG_MULT_COEFF     = 2'd0;
    localparam logic [1:0] CFG_ADD_COEFF      = 2'd1;
    localparam logic [1:0] CFG_BUCKETS_IN_USE = 2'd2;

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Status of the remainder unit
    typedef struct packed {
        logic             done;
        logic [MOD_W-1:0] rem;
    } hks_mod_status_t;

endpackage

### sv/hks_mod_unit.sv
// Restoring remainder unit: one dividend bit per cycle.
module hks_mod_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic [hks_pkg::HASH_W-1:0]  dividend,
    input  logic [hks_pkg::MOD_W-1:0]   divisor,
    output hks_pkg::hks_mod_status_t    status
);

    localparam int CW = $clog2(hks_pkg::HASH_W);

    logic [hks_pkg::HASH_W-1:0] shift_reg, shift_next;
    logic [hks_pkg::MOD_W-1:0]  rem_reg, rem_next;
    logic [hks_pkg::MOD_W-1:0]  div_reg, div_next;
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic                       active_reg, active_next;
    logic                       done_reg, done_next;
    logic [hks_pkg::MOD_W:0]    trial;

    // Load, or one remainder step
    always_comb
    begin
        trial       = {rem_reg, shift_reg[hks_pkg::HASH_W-1]};
        shift_next  = shift_reg;
        rem_next    = rem_reg;
        div_next    = div_reg;
        cnt_next    = cnt_reg;
        active_next = active_reg;
        done_next   = 1'b0;
        if (load)
        begin
            shift_next  = dividend;
            rem_next    = '0;
            div_next    = divisor;
            cnt_next    = CW'(hks_pkg::HASH_W - 1);
            active_next = 1'b1;
        end
        else if (active_reg)
        begin
            shift_next = {shift_reg[hks_pkg::HASH_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = hks_pkg::MOD_W'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = trial[hks_pkg::MOD_W-1:0];
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Datapath, no reset
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
    end

    assign status.done = done_reg;
    assign status.rem  = rem_reg;

endmodule

### sv/hashed_key_set.sv
// An item passes through the multiply, the add and the bit-serial remainder, then the
// bucket locate; an insert then writes one slot, a lookup scans the bucket one slot per
// cycle up to its fill (at most BUCKET_DEPTH) and stops early on a hit.
// One item at a time: busy is high from accept until the result strobe.
// The receiver cannot stall: done is a one-cycle strobe.
// Reset clears all bucket fill counts and loads the hash registers (a=1, b=0, 16).
module hashed_key_set
#(
    parameter int NUM_BUCKETS  = 16,
    parameter int BUCKET_DEPTH = 8,
    parameter int KEY_WIDTH    = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               operation,
    input  logic signed [31:0] key,
    output logic               done,
    output logic               found,
    output logic               overflow,
    output logic [3:0]         bucket,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int SLOTS = NUM_BUCKETS * BUCKET_DEPTH;
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int BW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int FW    = $clog2(BUCKET_DEPTH + 1);
    localparam int SW    = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
    localparam int MW    = hks_pkg::MOD_W;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_MUL    = 7'b0000010,
        ST_ADD    = 7'b0000100,
        ST_DIV    = 7'b0001000,
        ST_LOCATE = 7'b0010000,
        ST_INSERT = 7'b0100000,
        ST_SCAN   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration
    logic [31:0]   mult_reg;
    logic [31:0]   add_reg;
    logic [MW-1:0] biu_reg;

    // Item registers
    logic                        op_reg, op_next;
    logic [31:0]                 key_reg, key_next;
    logic [hks_pkg::HASH_W-1:0]  hash_reg, hash_next;
    logic [MW-1:0]               mod_reg, mod_next;
    logic [BW-1:0]               b_reg, b_next;
    logic [AW-1:0]               base_reg, base_next;
    logic [FW-1:0]               fill_cur_reg, fill_cur_next;
    logic [FW-1:0]               idx_reg, idx_next;
    logic                        pend_reg, pend_next;

    // Results
    logic       done_reg, done_next;
    logic       found_reg, found_next;
    logic       overflow_reg, overflow_next;
    logic [3:0] bucket_reg, bucket_next;

    // Fill counts and slot memory
    logic [FW-1:0] fill_arr [NUM_BUCKETS];
    logic [SW-1:0] slot_mem [SLOTS];
    logic [SW-1:0] mem_q;
    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;

    // Remainder unit
    logic                      mod_load;
    hks_pkg::hks_mod_status_t  mod_status;
    logic [BW+MW-1:0]          rem_ext;
    logic [BW+3:0]             b_ext;
    logic                      issue, hit;

    hks_mod_unit u_mod
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (mod_load),
        .dividend (hash_reg + add_reg),
        .divisor  (mod_reg),
        .status   (mod_status)
    );

    assign rem_ext = {{BW{1'b0}}, mod_status.rem};
    assign b_ext   = {4'b0000, b_reg};
    assign issue   = idx_reg < fill_cur_reg;
    assign hit     = pend_reg && (mem_q == key_reg[SW-1:0]);
    assign rd_addr = base_reg + AW'(idx_reg);
    assign wr_addr = base_reg + AW'(fill_cur_reg);

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        hash_next     = hash_reg;
        mod_next      = mod_reg;
        b_next        = b_reg;
        base_next     = base_reg;
        fill_cur_next = fill_cur_reg;
        idx_next      = idx_reg;
        pend_next     = 1'b0;
        done_next     = 1'b0;
        found_next    = found_reg;
        overflow_next = overflow_reg;
        bucket_next   = bucket_reg;
        mod_load      = 1'b0;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next    = operation;
                    key_next   = key;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                hash_next = mult_reg * key_reg;
                if (biu_reg == '0)
                begin
                    mod_next = MW'(1);
                end
                else if (32'(biu_reg) > NUM_BUCKETS)
                begin
                    mod_next = MW'(NUM_BUCKETS);
                end
                else
                begin
                    mod_next = biu_reg;
                end
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                mod_load   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (mod_status.done)
                begin
                    b_next     = rem_ext[BW-1:0];
                    state_next = ST_LOCATE;
                end
            end
            ST_LOCATE:
            begin
                base_next     = AW'(b_reg * BUCKET_DEPTH);
                fill_cur_next = fill_arr[b_reg];
                idx_next      = '0;
                if (op_reg == hks_pkg::OP_INSERT)
                begin
                    state_next = ST_INSERT;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_INSERT:
            begin
                wr_en         = fill_cur_reg < FW'(BUCKET_DEPTH);
                found_next    = 1'b0;
                overflow_next = !wr_en;
                bucket_next   = b_ext[3:0];
                done_next     = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (hit || (!issue && !pend_reg))
                begin
                    found_next    = hit;
                    overflow_next = 1'b0;
                    bucket_next   = b_ext[3:0];
                    done_next     = 1'b1;
                    state_next    = ST_IDLE;
                end
                else if (issue)
                begin
                    rd_en     = 1'b1;
                    idx_next  = FW'(idx_reg + 1'b1);
                    pend_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control, result, fill count and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pend_reg     <= 1'b0;
            done_reg     <= 1'b0;
            found_reg    <= 1'b0;
            overflow_reg <= 1'b0;
            bucket_reg   <= '0;
            mult_reg     <= 32'd1;
            add_reg      <= 32'd0;
            biu_reg      <= MW'(16);
            for (int i = 0; i < NUM_BUCKETS; i++)
            begin
                fill_arr[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            pend_reg     <= pend_next;
            done_reg     <= done_next;
            found_reg    <= found_next;
            overflow_reg <= overflow_next;
            bucket_reg   <= bucket_next;
            if (wr_en)
            begin
                fill_arr[b_reg] <= FW'(fill_cur_reg + 1'b1);
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    hks_pkg::CFG_MULT_COEFF:     mult_reg <= cfg_data;
                    hks_pkg::CFG_ADD_COEFF:      add_reg  <= cfg_data;
                    hks_pkg::CFG_BUCKETS_IN_USE: biu_reg  <= cfg_data[MW-1:0];
                    default:                     ;
                endcase
            end
        end
    end

    // Item datapath, no reset
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        hash_reg     <= hash_next;
        mod_reg      <= mod_next;
        b_reg        <= b_next;
        base_reg     <= base_next;
        fill_cur_reg <= fill_cur_next;
        idx_reg      <= idx_next;
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= key_reg[SW-1:0];
        end
        if (rd_en)
        begin
            mem_q <= slot_mem[rd_addr];
        end
    end

    // Register writes only between items, never in the cycle an item is taken
    assign busy      = state_reg != ST_IDLE;
    assign cfg_ready = !busy && !start;
    assign done      = done_reg;
    assign found     = found_reg;
    assign overflow  = overflow_reg;
    assign bucket    = bucket_reg;

    // Checks
    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result beat");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(found && overflow))
        else $error("found and overflow both set");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INSERT || state_reg == ST_SCAN)
            |-> (fill_cur_reg <= FW'(BUCKET_DEPTH)))
        else $error("bucket fill beyond depth");

endmodule
